/* rtl/core/bpe_pkg.sv */
// bpe_pkg: shared constants for the band pair energy integrand pipeline
// register indexes, reset values, sine polynomial coefficients
// no dependencies
package bpe_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int WORD_BITS    = 32;
  localparam int SINE_LAT     = 9;
  localparam int N_REGS       = 8;
  localparam int CFG_IDX_BITS = 4;
  localparam int IN_BITS      = 32;
  localparam int OUT_BITS     = 192;
  localparam int USER_BITS    = 2;

  typedef enum logic [2:0] {
    REG_HOP_TH        = 3'd0,
    REG_HOP_T0        = 3'd1,
    REG_HOP_THP       = 3'd2,
    REG_HOP_TZ        = 3'd3,
    REG_ANISO_ALPHA   = 3'd4,
    REG_ORDER_D1      = 3'd5,
    REG_ORDER_F0      = 3'd6,
    REG_ENERGY_OFFSET = 3'd7
  } reg_idx_t;

  localparam logic [31:0] REG_RESET [0:N_REGS-1] = '{
    32'd65536, 32'd65536, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0
  };

  // odd taylor terms of sin(pi/2*u), q30
  localparam logic [31:0] SINE_COEF [0:6] = '{
    32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026994,
    32'd172272, 32'd3864, 32'd61
  };

endpackage

/* rtl/core/bpe_sine.sv */
// bpe_sine: pipelined fixed point sine of a turn fraction
// quarter fold, horner on u^2 one term per stage; uses bpe_pkg
module bpe_sine #(
  parameter int ANGLE_BITS = bpe_pkg::ANGLE_BITS,
  parameter int FRAC_BITS  = bpe_pkg::FRAC_BITS,
  parameter int WORD_BITS  = bpe_pkg::WORD_BITS
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic signed [WORD_BITS-1:0] sine,
  output logic                        sat
);

  localparam int QB = ANGLE_BITS - 2;
  localparam int W  = WORD_BITS;

  logic [1:0]    quad;
  logic [QB-1:0] p;
  logic [QB:0]   x;

  assign quad = angle[ANGLE_BITS-1 -: 2];
  assign p    = angle[QB-1:0];
  assign x    = quad[0] ? ({1'b1, {QB{1'b0}}} - {1'b0, p}) : {1'b0, p};

  logic [30:0] u1;
  logic        n1;
  logic [61:0] sqp;

  always_ff @(posedge clk) begin
    if (en) begin
      u1 <= 31'(x) << (30 - QB);
      n1 <= quad[1];
    end
  end

  assign sqp = {31'b0, u1} * {31'b0, u1};

  logic [30:0] hu   [0:6];
  logic [30:0] hu2  [0:6];
  logic [31:0] hacc [0:6];
  logic        hneg [0:6];

  always_ff @(posedge clk) begin
    if (en) begin
      hu[0]   <= u1;
      hu2[0]  <= sqp[60:30];
      hacc[0] <= bpe_pkg::SINE_COEF[6];
      hneg[0] <= n1;
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_horner
    logic [62:0] hp;
    assign hp = {31'b0, hacc[k]} * {32'b0, hu2[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        hu[k+1]   <= hu[k];
        hu2[k+1]  <= hu2[k];
        hacc[k+1] <= bpe_pkg::SINE_COEF[5-k] - hp[61:30];
        hneg[k+1] <= hneg[k];
      end
    end
  end

  logic [62:0] fp;
  logic [32:0] s;
  logic [30:0] capped;
  logic [63:0] m64;
  logic [63:0] lim;

  assign fp     = {32'b0, hu[6]} * {31'b0, hacc[6]};
  assign s      = fp[62:30];
  assign capped = (s > 33'(32'd1 << 30)) ? 31'(32'd1 << 30) : s[30:0];
  assign m64    = 64'(capped >> (30 - FRAC_BITS));
  assign lim    = 64'd1 << (W - 1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (hneg[6]) begin
        sat  <= m64 > lim;
        sine <= (m64 > lim) ? {1'b1, {(W-1){1'b0}}} : W'(~m64 + 64'd1);
      end else begin
        sat  <= m64 >= lim;
        sine <= (m64 >= lim) ? {1'b0, {(W-1){1'b1}}} : W'(m64);
      end
    end
  end

endmodule

/* rtl/core/band_pair_energy_integrands.sv */
// band_pair_energy_integrands: register pipeline from two angles to band pair energy and integrands
// one beat per cycle while the output is not held; every stage is a register stage and all stages
// advance together whenever the output register is empty or taken
// the sqrt (one root bit per stage) and the two dividers (one quotient bit per
// stage) set the depth; reset clears all valid bits and loads register defaults
module band_pair_energy_integrands #(
  parameter int ANGLE_BITS = bpe_pkg::ANGLE_BITS,
  parameter int FRAC_BITS  = bpe_pkg::FRAC_BITS,
  parameter int WORD_BITS  = bpe_pkg::WORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bpe_pkg::IN_BITS-1:0]       s_tdata,   // kx_angle, ky_angle
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // band_xi, gap_value, pair_energy, integrand_d1, integrand_mu, integrand_f0, pad
  output logic [bpe_pkg::OUT_BITS-1:0]      m_tdata,
  output logic [bpe_pkg::USER_BITS-1:0]     m_tuser,   // degenerate, saturated
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int SL    = bpe_pkg::SINE_LAT;
  localparam int DEPTH = SL + 11 + 2 * W;
  localparam int XW    = 2 * W + F + 2;

  typedef logic signed [W-1:0] word_t;
  typedef struct packed { logic sat; word_t v; } sw_t;
  typedef struct packed {
    word_t xi; word_t gap; word_t ww; word_t sxy; logic wws; logic sat;
  } cy_t;
  typedef struct packed {
    logic [W+F-1:0] dd; logic [W+1:0] rem; logic [W-2:0] q; logic sat;
  } dl_t;

  localparam word_t WMAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(W-1){1'b0}}};

  function automatic sw_t f_add(word_t a, word_t b);
    logic signed [W:0] s;
    sw_t r;
    s = {a[W-1], a} + {b[W-1], b};
    r.sat = s[W] ^ s[W-1];
    r.v = r.sat ? (s[W] ? WMIN : WMAX) : s[W-1:0];
    return r;
  endfunction

  function automatic sw_t f_sub(word_t a, word_t b);
    logic signed [W:0] s;
    sw_t r;
    s = {a[W-1], a} - {b[W-1], b};
    r.sat = s[W] ^ s[W-1];
    r.v = r.sat ? (s[W] ? WMIN : WMAX) : s[W-1:0];
    return r;
  endfunction

  function automatic logic [W-1:0] f_mag(word_t a);
    return a[W-1] ? (~a + W'(1)) : a;
  endfunction

  function automatic sw_t f_mul(word_t a, word_t b);
    logic [2*W-1:0] pr;
    logic [2*W-1:0] m;
    logic [2*W-1:0] lim;
    logic           neg;
    sw_t            r;
    neg = a[W-1] ^ b[W-1];
    pr  = {{W{1'b0}}, f_mag(a)} * {{W{1'b0}}, f_mag(b)};
    m   = pr >> F;
    lim = (2*W)'(1) << (W - 1);
    if (neg) begin
      r.sat = m > lim;
      r.v   = r.sat ? WMIN : W'(~m + (2*W)'(1));
    end else begin
      r.sat = m >= lim;
      r.v   = r.sat ? WMAX : W'(m);
    end
    return r;
  endfunction

  function automatic sw_t f_neg(word_t a);
    sw_t r;
    r.sat = (a == WMIN);
    r.v   = r.sat ? WMAX : -a;
    return r;
  endfunction

  function automatic sw_t f_quad(word_t a);
    sw_t d;
    sw_t e;
    d = f_add(a, a);
    e = f_add(d.v, d.v);
    e.sat = e.sat | d.sat;
    return e;
  endfunction

  function automatic sw_t f_clamp(logic signed [31:0] x);
    logic signed [63:0] x64;
    sw_t r;
    x64 = 64'(x);
    if (x64 > 64'(WMAX)) begin
      r.sat = 1'b1; r.v = WMAX;
    end else if (x64 < 64'(WMIN)) begin
      r.sat = 1'b1; r.v = WMIN;
    end else begin
      r.sat = 1'b0; r.v = W'(x64);
    end
    return r;
  endfunction

  function automatic dl_t f_dinit(logic [W-1:0] n, logic [W:0] d);
    dl_t l;
    l.dd  = {n, {F{1'b0}}};
    l.sat = XW'(l.dd) >= (XW'(d) << (W - 1));
    l.rem = (W+2)'(l.dd >> (W - 1));
    l.q   = '0;
    return l;
  endfunction

  function automatic dl_t f_dstep(dl_t l, logic [W:0] d, int b);
    logic [W+1:0] r2;
    logic         ge;
    dl_t          o;
    r2    = {l.rem[W:0], l.dd[b]};
    ge    = r2 >= {1'b0, d};
    o     = l;
    o.rem = ge ? (r2 - {1'b0, d}) : r2;
    o.q   = {l.q[W-3:0], ge};
    return o;
  endfunction

  // configuration registers
  logic [31:0] cfg_reg [0:bpe_pkg::N_REGS-1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bpe_pkg::N_REGS; i++) cfg_reg[i] <= bpe_pkg::REG_RESET[i];
    end else if (cfg_valid &&
                 cfg_index < bpe_pkg::CFG_IDX_BITS'(bpe_pkg::N_REGS)) begin
      cfg_reg[cfg_index[2:0]] <= cfg_data;
    end
  end

  sw_t   c_reg [0:bpe_pkg::N_REGS-1];
  sw_t   c_one;
  logic  cfg_sat;
  word_t th, t0, thp, tz, alpha, d1, f0, off, one;

  always_comb begin
    cfg_sat = 1'b0;
    for (int i = 0; i < bpe_pkg::N_REGS; i++) begin
      c_reg[i] = f_clamp(cfg_reg[i]);
      cfg_sat  = cfg_sat | c_reg[i].sat;
    end
    c_one   = f_clamp(32'sd1 << F);
    cfg_sat = cfg_sat | c_one.sat;
  end

  assign th    = c_reg[bpe_pkg::REG_HOP_TH].v;
  assign t0    = c_reg[bpe_pkg::REG_HOP_T0].v;
  assign thp   = c_reg[bpe_pkg::REG_HOP_THP].v;
  assign tz    = c_reg[bpe_pkg::REG_HOP_TZ].v;
  assign alpha = c_reg[bpe_pkg::REG_ANISO_ALPHA].v;
  assign d1    = c_reg[bpe_pkg::REG_ORDER_D1].v;
  assign f0    = c_reg[bpe_pkg::REG_ORDER_F0].v;
  assign off   = c_reg[bpe_pkg::REG_ENERGY_OFFSET].v;
  assign one   = c_one.v;

  // flow control
  logic             en;
  logic [DEPTH-1:0] vld;

  assign en       = ~vld[DEPTH-1] | m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // sines
  word_t sx, sy;
  logic  sx_sat, sy_sat;

  bpe_sine #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(F), .WORD_BITS(W)) u_sine_x (
    .clk(clk), .en(en), .angle(ANGLE_BITS'(s_tdata[15:0])), .sine(sx), .sat(sx_sat)
  );

  bpe_sine #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(F), .WORD_BITS(W)) u_sine_y (
    .clk(clk), .en(en), .angle(ANGLE_BITS'(s_tdata[31:16])), .sine(sy), .sat(sy_sat)
  );

  // m1
  sw_t   a_sxy, a_sum, a_ay, a_dt, a_tt;
  word_t m1_sx, m1_sxy, m1_sum, m1_ay, m1_dt, m1_tt;
  logic  m1_sat;

  assign a_sxy = f_mul(sx, sy);
  assign a_sum = f_add(sx, sy);
  assign a_ay  = f_mul(alpha, sy);
  assign a_dt  = f_mul(d1, t0);
  assign a_tt  = f_add(t0, tz);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_sx  <= sx;
      m1_sxy <= a_sxy.v;
      m1_sum <= a_sum.v;
      m1_ay  <= a_ay.v;
      m1_dt  <= a_dt.v;
      m1_tt  <= a_tt.v;
      m1_sat <= sx_sat | sy_sat | a_sxy.sat | a_sum.sat | a_ay.sat | a_dt.sat | a_tt.sat;
    end
  end

  // m2
  sw_t   b_sq, b_w, b_a, b_g1;
  word_t m2_sq, m2_w, m2_a, m2_g1, m2_sxy;
  logic  m2_sat;

  assign b_sq = f_mul(m1_sum, m1_sum);
  assign b_w  = f_add(m1_sx, m1_ay);
  assign b_a  = f_sub(m1_dt, thp);
  assign b_g1 = f_mul(f0, m1_tt);

  always_ff @(posedge clk) begin
    if (en) begin
      m2_sq  <= b_sq.v;
      m2_w   <= b_w.v;
      m2_a   <= b_a.v;
      m2_g1  <= b_g1.v;
      m2_sxy <= m1_sxy;
      m2_sat <= m1_sat | b_sq.sat | b_w.sat | b_a.sat | b_g1.sat;
    end
  end

  // m3
  sw_t   c_b, c_c, c_gg, c_ww;
  word_t m3_b, m3_c, m3_gg, m3_ww, m3_sxy;
  logic  m3_wws, m3_sat;

  assign c_b  = f_sub(m2_sq, one);
  assign c_c  = f_mul(m2_a, m2_sxy);
  assign c_gg = f_mul(m2_g1, m2_w);
  assign c_ww = f_mul(m2_w, m2_w);

  always_ff @(posedge clk) begin
    if (en) begin
      m3_b   <= c_b.v;
      m3_c   <= c_c.v;
      m3_gg  <= c_gg.v;
      m3_ww  <= c_ww.v;
      m3_wws <= c_ww.sat;
      m3_sxy <= m2_sxy;
      m3_sat <= m2_sat | c_b.sat | c_c.sat | c_gg.sat;
    end
  end

  // m4
  sw_t   d_e1, d_e2, d_gap;
  word_t m4_e1, m4_e2, m4_gap, m4_ww, m4_sxy;
  logic  m4_wws, m4_sat;

  assign d_e1  = f_mul(th, m3_b);
  assign d_e2  = f_quad(m3_c);
  assign d_gap = f_quad(m3_gg);

  always_ff @(posedge clk) begin
    if (en) begin
      m4_e1  <= d_e1.v;
      m4_e2  <= d_e2.v;
      m4_gap <= d_gap.v;
      m4_ww  <= m3_ww;
      m4_wws <= m3_wws;
      m4_sxy <= m3_sxy;
      m4_sat <= m3_sat | d_e1.sat | d_e2.sat | d_gap.sat;
    end
  end

  // m5
  sw_t e_dbl, e_s, e_xi;
  cy_t c5;

  assign e_dbl = f_add(m4_e1, m4_e1);
  assign e_s   = f_add(e_dbl.v, m4_e2);
  assign e_xi  = f_sub(e_s.v, off);

  always_ff @(posedge clk) begin
    if (en) begin
      c5.xi  <= e_xi.v;
      c5.gap <= m4_gap;
      c5.ww  <= m4_ww;
      c5.sxy <= m4_sxy;
      c5.wws <= m4_wws;
      c5.sat <= m4_sat | e_dbl.sat | e_s.sat | e_xi.sat;
    end
  end

  // m6, m7: sum of squares
  logic [W-1:0]   mx, mg;
  logic [2*W-1:0] m6_a, m6_b;
  logic [2*W+1:0] m7_n;
  cy_t            c6, c7;

  assign mx = f_mag(c5.xi);
  assign mg = f_mag(c5.gap);

  always_ff @(posedge clk) begin
    if (en) begin
      m6_a <= {{W{1'b0}}, mx} * {{W{1'b0}}, mx};
      m6_b <= {{W{1'b0}}, mg} * {{W{1'b0}}, mg};
      c6   <= c5;
      m7_n <= (2*W+2)'(m6_a) + (2*W+2)'(m6_b);
      c7   <= c6;
    end
  end

  // square root, one root bit per stage
  logic [2*W+1:0] sq_n    [0:W];
  logic [W+3:0]   sq_rem  [0:W];
  logic [W:0]     sq_root [0:W];
  cy_t            sq_c    [0:W];

  for (genvar i = 0; i <= W; i++) begin : g_sqrt
    logic [2*W+1:0] n_in;
    logic [W+3:0]   rem_in, rem_sh, trial;
    logic [W:0]     root_in;
    cy_t            c_in;
    logic           ge;

    if (i == 0) begin : g_first
      assign n_in    = m7_n;
      assign rem_in  = '0;
      assign root_in = '0;
      assign c_in    = c7;
    end else begin : g_next
      assign n_in    = sq_n[i-1];
      assign rem_in  = sq_rem[i-1];
      assign root_in = sq_root[i-1];
      assign c_in    = sq_c[i-1];
    end

    assign rem_sh = {rem_in[W+1:0], n_in[2*(W-i)+1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_n[i]    <= n_in;
        sq_rem[i]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_root[i] <= {root_in[W-1:0], ge};
        sq_c[i]    <= c_in;
      end
    end
  end

  // dividers, one quotient bit per stage
  dl_t        dx [0:W-1];
  dl_t        df [0:W-1];
  logic [W:0] de [0:W-1];
  cy_t        dc [0:W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dx[0] <= f_dinit(f_mag(sq_c[W].xi), sq_root[W]);
      df[0] <= f_dinit(f_mag(sq_c[W].ww), sq_root[W]);
      de[0] <= sq_root[W];
      dc[0] <= sq_c[W];
    end
  end

  for (genvar j = 1; j < W; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dx[j] <= f_dstep(dx[j-1], de[j-1], W - 1 - j);
        df[j] <= f_dstep(df[j-1], de[j-1], W - 1 - j);
        de[j] <= de[j-1];
        dc[j] <= dc[j-1];
      end
    end
  end

  // p1: ratio, half, pair energy cap
  word_t      qx, qf, rx, hv_adj;
  sw_t        h;
  logic       pe_sat;
  logic [W:0] e_last;

  assign e_last = de[W-1];
  assign qx     = dx[W-1].sat ? WMAX : {1'b0, dx[W-1].q};
  assign qf     = df[W-1].sat ? WMAX : {1'b0, df[W-1].q};
  assign rx     = dc[W-1].xi[W-1] ? -qx : qx;
  assign h      = f_sub(one, rx);
  assign hv_adj = h.v + word_t'({{(W-1){1'b0}}, h.v[W-1]});
  assign pe_sat = e_last > {1'b0, WMAX};

  word_t        p1_xi, p1_gap, p1_mu, p1_sxy, p1_f0;
  logic [W-1:0] p1_pe;
  logic         p1_degen, p1_sat, p1_snd;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_xi    <= dc[W-1].xi;
      p1_gap   <= dc[W-1].gap;
      p1_mu    <= hv_adj >>> 1;
      p1_sxy   <= dc[W-1].sxy;
      p1_f0    <= qf;
      p1_pe    <= pe_sat ? WMAX : e_last[W-1:0];
      p1_degen <= (e_last == '0);
      p1_sat   <= dc[W-1].sat | pe_sat | cfg_sat;
      p1_snd   <= dc[W-1].wws | dx[W-1].sat | df[W-1].sat | h.sat;
    end
  end

  // p2
  sw_t          g_prod;
  word_t        p2_xi, p2_gap, p2_mu, p2_f0, p2_prod;
  logic [W-1:0] p2_pe;
  logic         p2_degen, p2_sat, p2_snd;

  assign g_prod = f_mul(p1_mu, p1_sxy);

  always_ff @(posedge clk) begin
    if (en) begin
      p2_xi    <= p1_xi;
      p2_gap   <= p1_gap;
      p2_mu    <= p1_mu;
      p2_f0    <= p1_f0;
      p2_prod  <= g_prod.v;
      p2_pe    <= p1_pe;
      p2_degen <= p1_degen;
      p2_sat   <= p1_sat;
      p2_snd   <= p1_snd | g_prod.sat;
    end
  end

  // p3: output register
  sw_t          g_neg;
  word_t        o_xi, o_gap, o_d1, o_mu, o_f0;
  logic [W-1:0] o_pe;
  logic         o_degen, o_sat;

  assign g_neg = f_neg(p2_prod);

  always_ff @(posedge clk) begin
    if (en) begin
      o_xi    <= p2_xi;
      o_gap   <= p2_gap;
      o_pe    <= p2_pe;
      o_d1    <= p2_degen ? '0 : g_neg.v;
      o_mu    <= p2_degen ? '0 : p2_mu;
      o_f0    <= p2_degen ? '0 : p2_f0;
      o_degen <= p2_degen;
      o_sat   <= p2_sat | (~p2_degen & (p2_snd | g_neg.sat));
    end
  end

  assign m_tdata = {1'b0, 32'(o_f0), 32'(o_mu), 32'(o_d1), 31'(o_pe), 32'(o_gap), 32'(o_xi)};
  assign m_tuser = {o_sat, o_degen};

endmodule

/* rtl/core/bpe_chk.sv */
// bpe_chk: port level checks for band_pair_energy_integrands
// bound to the top level; uses bpe_pkg
module bpe_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [bpe_pkg::OUT_BITS-1:0]  m_tdata,
  input logic [bpe_pkg::USER_BITS-1:0] m_tuser
);

  // held output beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // input only stalls behind a held output
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // zero pair energy gives zero integrands
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[190:64] == '0)
    else $error("degenerate beat with nonzero energy or integrands");

  a_nondegen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[94:64] != '0)
    else $error("zero pair energy without degenerate flag");

endmodule

bind band_pair_energy_integrands bpe_chk u_bpe_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

/* dv/band_pair_energy_integrands_test.sv */
// band_pair_energy_integrands_test: self-checking bench for the band pair energy pipeline
// predicts every output beat from the register shadow and the two angles, compares in order
// depends on bpe_pkg and band_pair_energy_integrands
`timescale 1ns / 100ps

module band_pair_energy_integrands_test;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam longint ONE_Q = 64'sd65536;
  localparam int WATCHDOG_LIMIT = 10000;

  typedef struct packed {
    logic [31:0] xi;
    logic [31:0] gap;
    logic [30:0] pe;
    logic [31:0] d1;
    logic [31:0] mu;
    logic [31:0] f0;
    logic        degen;
    logic        sat;
  } point_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [bpe_pkg::IN_BITS-1:0]       s_tdata = '0;   // kx_angle, ky_angle
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [bpe_pkg::OUT_BITS-1:0]      m_tdata;  // xi, gap, pair energy, d1, mu, f0, pad
  logic [bpe_pkg::USER_BITS-1:0]     m_tuser;  // degenerate, saturated
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [bpe_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [31:0]                       cfg_data = '0;

  logic signed [31:0] reg_shadow [0:bpe_pkg::N_REGS-1];
  logic [31:0]        point_queue [$];
  point_result_t      result_queue [$];
  bit                 steady = 1'b0;
  bit                 clip;
  int                 errors = 0;
  int                 tx_wait = 0;
  int                 rx_wait = 0;
  int                 rx_hold = 0;
  int                 rx_count = 0;
  int                 quiet_cycles = 0;

  band_pair_energy_integrands uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // saturating word arithmetic
  function automatic longint clamp_word(longint v);
    if (v > WMAX) begin
      clip = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      clip = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  function automatic longint from_mag(longint unsigned m, bit neg);
    if (neg) begin
      if (m > 64'd2147483648) begin
        clip = 1'b1;
        return WMIN;
      end
      return -longint'(m);
    end
    if (m > 64'd2147483647) begin
      clip = 1'b1;
      return WMAX;
    end
    return longint'(m);
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    longint unsigned m;
    p = a * b;
    m = (p < 0) ? longint'(-p) : p;
    return from_mag(m >> bpe_pkg::FRAC_BITS, (a < 0) != (b < 0));
  endfunction

  function automatic longint quad_times(longint a);
    longint d;
    d = clamp_word(a + a);
    return clamp_word(d + d);
  endfunction

  function automatic longint unsigned qdiv(longint unsigned n, longint unsigned d);
    if (n / d > 64'd32767) begin
      clip = 1'b1;
      return 64'd2147483647;
    end
    return (n << bpe_pkg::FRAC_BITS) / d;
  endfunction

  function automatic longint unsigned mag_of(longint a);
    return (a < 0) ? longint'(-a) : a;
  endfunction

  function automatic longint sine_q(logic [15:0] ang);
    logic [63:0] p, x, u, u2, acc, s;
    int k;
    p = {50'd0, ang[13:0]};
    x = ang[14] ? 64'd16384 - p : p;
    u = x << 16;
    u2 = (u * u) >> 30;
    acc = {32'd0, bpe_pkg::SINE_COEF[6]};
    for (k = 5; k >= 0; k--) acc = {32'd0, bpe_pkg::SINE_COEF[k]} - ((acc * u2) >> 30);
    s = (u * acc) >> 30;
    if (s > 64'd1073741824) s = 64'd1073741824;
    s = s >> (30 - bpe_pkg::FRAC_BITS);
    return from_mag(s, ang[15]);
  endfunction

  function automatic point_result_t predict_point(logic [31:0] beat);
    point_result_t r;
    longint th, t0, thp, tz, alpha, d1, f0, off;
    longint sx, sy, sxy, sum, e1, e2, xi, w, gap, ratio, h, mu, ig_d1, ig_f0;
    longint unsigned nsq, root, cand, pe;
    clip = 1'b0;
    th = reg_shadow[bpe_pkg::REG_HOP_TH];
    t0 = reg_shadow[bpe_pkg::REG_HOP_T0];
    thp = reg_shadow[bpe_pkg::REG_HOP_THP];
    tz = reg_shadow[bpe_pkg::REG_HOP_TZ];
    alpha = reg_shadow[bpe_pkg::REG_ANISO_ALPHA];
    d1 = reg_shadow[bpe_pkg::REG_ORDER_D1];
    f0 = reg_shadow[bpe_pkg::REG_ORDER_F0];
    off = reg_shadow[bpe_pkg::REG_ENERGY_OFFSET];
    sx = sine_q(beat[15:0]);
    sy = sine_q(beat[31:16]);
    sxy = qmul(sx, sy);
    sum = clamp_word(sx + sy);
    e1 = qmul(th, clamp_word(qmul(sum, sum) - ONE_Q));
    e1 = clamp_word(e1 + e1);
    e2 = quad_times(qmul(clamp_word(qmul(d1, t0) - thp), sxy));
    xi = clamp_word(clamp_word(e1 + e2) - off);
    w = clamp_word(sx + qmul(alpha, sy));
    gap = quad_times(qmul(qmul(f0, clamp_word(t0 + tz)), w));
    nsq = mag_of(xi) * mag_of(xi) + mag_of(gap) * mag_of(gap);
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= nsq) root = cand;
    end
    pe = root;
    if (pe > 64'd2147483647) begin
      clip = 1'b1;
      pe = 64'd2147483647;
    end
    mu = 0;
    ig_d1 = 0;
    ig_f0 = 0;
    if (root != 0) begin
      ratio = from_mag(qdiv(mag_of(xi), root), xi < 0);
      h = clamp_word(ONE_Q - ratio);
      mu = h / 2;
      ig_d1 = clamp_word(-qmul(mu, sxy));
      ig_f0 = qdiv(mag_of(qmul(w, w)), root);
    end
    r.xi = xi[31:0];
    r.gap = gap[31:0];
    r.pe = pe[30:0];
    r.d1 = ig_d1[31:0];
    r.mu = mu[31:0];
    r.f0 = ig_f0[31:0];
    r.degen = (root == 0);
    r.sat = clip;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) result_queue.push_back(predict_point(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_tvalid <= 1'b0;
        end else if (point_queue.size() > 0) begin
          s_tdata <= point_queue.pop_front();
          s_tvalid <= 1'b1;
          tx_wait = steady ? 0 : $urandom_range(0, 16);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    point_result_t want, got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[63:32], m_tdata[94:64], m_tdata[126:95],
               m_tdata[158:127], m_tdata[190:159], m_tuser[0], m_tuser[1]};
        rx_count++;
        if (result_queue.size() == 0) begin
          $display("%0t unexpected beat actual %h", $time, got);
          errors++;
        end else begin
          want = result_queue.pop_front();
          check_field("band_xi", want.xi, got.xi);
          check_field("gap_value", want.gap, got.gap);
          check_field("pair_energy", want.pe, got.pe);
          check_field("integrand_d1", want.d1, got.d1);
          check_field("integrand_mu", want.mu, got.mu);
          check_field("integrand_f0", want.f0, got.f0);
          check_field("degenerate", want.degen, got.degen);
          check_field("saturated", want.sat, got.sat);
        end
        rx_wait = steady ? 0 : $urandom_range(0, 16);
        if (rx_count == 410) rx_hold = 2000;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input bpe_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    reg_shadow[idx] = value;
  endtask

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return 32'd65536;
      4: return -32'sd65536;
      5: return $urandom_range(0, 1 << 19) - (1 << 18);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 4) == 0)
      return 16'({$urandom_range(0, 3), 14'd0} + $urandom_range(0, 4) - 2);
    return $urandom_range(0, 65535);
  endfunction

  task automatic settle();
    do @(posedge clk); while (point_queue.size() > 0 || s_tvalid || result_queue.size() > 0);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    logic [31:0] corner [$] = '{
      32'h0000_0000, 32'h0000_4000, 32'h4000_0000, 32'h4000_4000, 32'h8000_8000,
      32'hC000_C000, 32'hFFFF_FFFF, 32'hC000_4000, 32'h4000_C000, 32'h2000_2000,
      32'hFFFF_0001, 32'h0001_FFFF, 32'hA000_6000, 32'h5555_AAAA, 32'hAAAA_5555,
      32'h4001_3FFF, 32'h8001_7FFF, 32'hC001_BFFF, 32'h0000_8000, 32'h0000_C000
    };
    logic [31:0] values [0:bpe_pkg::N_REGS-1];
    int n_items;
    for (int i = 0; i < bpe_pkg::N_REGS; i++) reg_shadow[i] = bpe_pkg::REG_RESET[i];
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 8; phase++) begin
      for (int i = 0; i < bpe_pkg::N_REGS; i++) begin
        case (phase)
          0: values[i] = bpe_pkg::REG_RESET[i];
          1: values[i] = 32'h7FFF_FFFF;
          2: values[i] = 32'h8000_0000;
          default: values[i] = pick_reg();
        endcase
      end
      if (phase != 0) settle();
      for (int i = 0; i < bpe_pkg::N_REGS; i++) write_reg(bpe_pkg::reg_idx_t'(i), values[i]);
      cfg_valid <= 1'b0;
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 0) foreach (corner[j]) point_queue.push_back(corner[j]);
      n_items = (phase == 1 || phase == 2) ? 120 : 140;
      repeat (n_items) point_queue.push_back({pick_angle(), pick_angle()});
    end
    settle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
